// ===== rtl/rsd_pkg.sv =====
// shared types, constants and pixel helpers of the run-length sprite decoder
package rsd_pkg;

  // coordinate width and its largest value
  localparam int CoordBits = 12;
  localparam logic [CoordBits-1:0] CoordMax = {CoordBits{1'b1}};

  // stream codes and colours
  localparam logic [7:0]  SkipCode  = 8'hff;
  localparam logic [15:0] KeyColour = 16'hf81f;
  localparam logic [7:0]  OpaqueA   = 8'hff;

  // configuration register indexes
  localparam logic CfgWidth = 1'b0;
  localparam logic CfgAlpha = 1'b1;

  // decoder phase
  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_SKIP = 2'd1,
    PH_PIX  = 2'd2,
    PH_HIGH = 2'd3
  } phase_t;

  // request to the skip unit
  typedef struct packed {
    logic                 start;
    logic [CoordBits:0]   x_sum;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] width;
  } skip_req_t;

  // status of the skip unit
  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
  } skip_rsp_t;

  // 5-bit channel to 8 bits, top bits repeated below
  function automatic logic [7:0] expand5(input logic [4:0] v);
    expand5 = {v, v[4:2]};
  endfunction

  // rgb555 to opaque argb8888 with the green quirk kept
  function automatic logic [31:0] rgb555_to_argb(input logic [15:0] c);
    rgb555_to_argb = {OpaqueA, c[14:10], c[14:12], c[9:5], 1'b0, c[9:8],
                      c[4:0], c[4:2]};
  endfunction

  // saturating increment of a row
  function automatic logic [CoordBits-1:0] row_inc(input logic [CoordBits-1:0] y);
    row_inc = (y == CoordMax) ? y : y + 1'b1;
  endfunction

endpackage

// ===== rtl/rle_sprite_pixel_decoder.sv =====
// top level of the run-length sprite decoder: sequencer, position and output register
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data_byte, in_last_byte
//  out     | output    | out_valid/out_stall| out_pos_x, out_pos_y, out_argb, out_alpha_only
//  cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// code and pixel bytes are accepted back to back; the result sits in an output register.
// a skip count byte is handed to the skip unit, which wraps it into rows and
// subtracts the width once per cycle; input is stalled while it runs.
// reset is synchronous active low: width 58, colour mode, position 0, code phase.
// a full output register that is stalled holds back the input.
module rle_sprite_pixel_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rsd_pkg::CoordBits-1:0] out_pos_x,
  output logic [rsd_pkg::CoordBits-1:0] out_pos_y,
  output logic [31:0]                   out_argb,
  output logic                          out_alpha_only,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rsd_pkg::CoordBits-1:0] cfg_wdata
);

  localparam int Cb = rsd_pkg::CoordBits;

  rsd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]    run_r, run_nxt;
  logic [7:0]    low_r, low_nxt;
  logic [Cb-1:0] x_r, x_nxt;
  logic [Cb-1:0] y_r, y_nxt;
  logic [Cb-1:0] width_r;
  logic          alpha_r;

  logic          out_valid_r, out_valid_nxt;
  logic [Cb-1:0] out_x_r, out_y_r;
  logic [31:0]   out_argb_r;
  logic          out_ao_r;

  logic          in_acc, out_acc;
  logic          emit;
  logic [31:0]   pix_argb;
  logic          pix_ao;
  logic [Cb-1:0] w_eff;
  logic [Cb-1:0] x_inc;
  logic [7:0]    run_dec;
  logic [15:0]   colour;

  rsd_pkg::skip_req_t skip_req;
  rsd_pkg::skip_rsp_t skip_rsp;

  rsd_skip_unit u_skip (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (skip_req),
    .rsp   (skip_rsp)
  );

  // handshakes
  assign in_stall = skip_rsp.busy || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  // helpers
  assign w_eff   = (width_r == '0) ? {{(Cb-1){1'b0}}, 1'b1} : width_r;
  assign x_inc   = x_r + 1'b1;
  assign run_dec = run_r - 8'd1;
  assign colour  = {in_data_byte, low_r};

  // sequencer: next phase, position and pixel
  always_comb begin
    phase_nxt      = phase_r;
    run_nxt        = run_r;
    low_nxt        = low_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    emit           = 1'b0;
    pix_argb       = '0;
    pix_ao         = 1'b0;
    skip_req.start = 1'b0;
    skip_req.x_sum = {1'b0, x_r} + {{(Cb-7){1'b0}}, in_data_byte};
    skip_req.y     = y_r;
    skip_req.width = w_eff;
    if (skip_rsp.done) begin
      x_nxt = skip_rsp.x;
      y_nxt = skip_rsp.y;
    end
    if (in_acc) begin
      unique case (phase_r)
        rsd_pkg::PH_CODE: begin
          if (in_data_byte == rsd_pkg::SkipCode) begin
            phase_nxt = rsd_pkg::PH_SKIP;
          end else if (in_data_byte != 8'd0) begin
            run_nxt   = in_data_byte;
            phase_nxt = rsd_pkg::PH_PIX;
          end
        end
        rsd_pkg::PH_SKIP: begin
          skip_req.start = !in_last_byte;
          phase_nxt      = rsd_pkg::PH_CODE;
        end
        rsd_pkg::PH_PIX: begin
          if (!alpha_r) begin
            low_nxt   = in_data_byte;
            phase_nxt = rsd_pkg::PH_HIGH;
          end else begin
            emit     = 1'b1;
            pix_argb = {rsd_pkg::expand5(in_data_byte[4:0]), 24'd0};
            pix_ao   = 1'b1;
          end
        end
        rsd_pkg::PH_HIGH: begin
          emit     = (colour != rsd_pkg::KeyColour);
          pix_argb = rsd_pkg::rgb555_to_argb(colour);
        end
        default: begin
          phase_nxt = rsd_pkg::PH_CODE;
        end
      endcase
      // end of a pixel: step the position and the run
      if (phase_r == rsd_pkg::PH_HIGH || (phase_r == rsd_pkg::PH_PIX && alpha_r)) begin
        if (x_inc >= w_eff || x_inc == '0) begin
          x_nxt = '0;
          y_nxt = rsd_pkg::row_inc(y_r);
        end else begin
          x_nxt = x_inc;
        end
        run_nxt   = run_dec;
        phase_nxt = (run_dec == 8'd0) ? rsd_pkg::PH_CODE : rsd_pkg::PH_PIX;
      end
      // final byte of an image
      if (in_last_byte) begin
        phase_nxt = rsd_pkg::PH_CODE;
        run_nxt   = 8'd0;
        low_nxt   = 8'd0;
        x_nxt     = '0;
        y_nxt     = '0;
      end
    end
  end

  // output register fill and drain
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rsd_pkg::PH_CODE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // decoder state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 8'd0;
      low_r       <= 8'd0;
      x_r         <= '0;
      y_r         <= '0;
      width_r     <= Cb'(58);
      alpha_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      low_r       <= low_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          rsd_pkg::CfgWidth: width_r <= cfg_wdata;
          rsd_pkg::CfgAlpha: alpha_r <= cfg_wdata[0];
          default:           width_r <= width_r;
        endcase
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_x_r    <= x_r;
      out_y_r    <= y_r;
      out_argb_r <= pix_argb;
      out_ao_r   <= pix_ao;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pos_x      = out_x_r;
  assign out_pos_y      = out_y_r;
  assign out_argb       = out_argb_r;
  assign out_alpha_only = out_ao_r;

  // a started skip keeps the input stalled on the next cycle
  a_skip_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    skip_req.start |=> in_stall)
    else $error("skip started without stalling input");

  // while the skip unit runs the sequencer waits for a code byte
  a_busy_code: assert property (@(posedge clk) disable iff (!rst_n)
    skip_rsp.busy |-> phase_r == rsd_pkg::PH_CODE)
    else $error("skip unit busy outside code phase");

  // a stalled result is neither lost nor changed
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_argb_r) && $stable(out_x_r))
    else $error("stalled result changed");

endmodule

// ===== rtl/rsd_skip_unit.sv =====
// iterative subtract unit that wraps a skipped column into rows
module rsd_skip_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  rsd_pkg::skip_req_t req,
  output rsd_pkg::skip_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic [rsd_pkg::CoordBits:0]   rem_r, rem_nxt;
  logic [rsd_pkg::CoordBits-1:0] y_r, y_nxt;
  logic [rsd_pkg::CoordBits-1:0] w_r, w_nxt;
  logic                          fits;

  // one compare and subtract per cycle
  always_comb begin
    fits     = rem_r >= {1'b0, w_r};
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    y_nxt    = y_r;
    w_nxt    = w_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = req.x_sum;
      y_nxt    = req.y;
      w_nxt    = req.width;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - {1'b0, w_r};
        y_nxt   = rsd_pkg::row_inc(y_r);
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    y_r   <= y_nxt;
    w_r   <= w_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = busy_r && !fits;
  assign rsp.x    = rem_r[rsd_pkg::CoordBits-1:0];
  assign rsp.y    = y_r;

endmodule
